// ===== rtl/gfpa_pkg.sv =====
// Shared types, constants and helpers for the growable frame pool allocator.
package gfpa_pkg;

   localparam int FRAME_W        = 8;
   localparam int CNT_W          = 9;
   localparam int POOL_DEPTH     = 256;
   localparam int MAX_FRAMES_DEF = 256;
   localparam int RESET_POOL     = 16;
   localparam int RSP_DATA_W     = 40;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_INVALID = 2'd2
   } status_type;

   typedef struct packed {
      op_type              op;
      logic [FRAME_W-1:0]  frame;
   } item_type;

   typedef struct packed {
      logic              we;
      logic [CNT_W-1:0]  size;
   } restart_type;

   // Initial pool size clamped into 1..cap.
   function automatic logic [CNT_W-1:0] clamp_size(input logic [CNT_W-1:0] value,
                                                   input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] n;
      n = value;
      if (n == '0) n = CNT_W'(1);
      if (n > cap) n = cap;
      return n;
   endfunction

endpackage

// ===== rtl/growable_frame_pool_allocator.sv =====
// Top level of the growable frame pool allocator.
// Path: request accept into the decode queue, then the engine, then its result register.
// The engine takes no new item until the last one has left it: it reads the free-frame
// FIFO memory in its idle state, then updates in exec, stalling while a held result waits.
// Reset: synchronous; pool restarts with 16 fresh frames and an empty allocation map,
// and a csr write restarts it the same way with the written size. No clearing pass.
module growable_frame_pool_allocator
   import gfpa_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [FRAME_W-1:0]     req_tdata,   // [7:0] frame_index
   input  logic [0:0]             req_tuser,   // [0] command
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] granted_frame, [16:8] allocated_count, [25:17] free_count,
   // [34:26] current_pool_size, [39:35] zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic [1:0]             rsp_tuser,   // [1:0] status
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CNT_W-1:0]       csr_data     // [8:0] initial_pool_size
);

   logic         q_valid;
   logic         q_pop;
   item_type     q_item;
   restart_type  restart;

   assign csr_ready    = 1'b1;
   assign restart.we   = csr_valid && csr_ready;
   assign restart.size = csr_data;

   gfpa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   gfpa_back #(.MAX_FRAMES(MAX_FRAMES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/gfpa_front.sv =====
// Request front end: accepts items, decodes the command and queues them for the engine.
module gfpa_front
   import gfpa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [FRAME_W-1:0]  req_tdata,   // [7:0] frame_index
   input  logic [0:0]          req_tuser,   // [0] command
   output logic                q_valid,
   output item_type            q_item,
   input  logic                q_pop
);

   item_type    slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;
   item_type    item;

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      item.op    = req_tuser[0] ? OP_FREE : OP_ALLOC;
      item.frame = req_tdata;
      wr_ptr_in  = wr_ptr_ff ^ push;
      rd_ptr_in  = rd_ptr_ff ^ (q_pop && q_valid);
      cnt_in     = cnt_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== rtl/gfpa_back.sv =====
// Allocation engine: fresh-frame counter, free-frame FIFO memory, allocation map, result register.
module gfpa_back
   import gfpa_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   input  restart_type            restart,
   input  logic                   q_valid,
   input  item_type               q_item,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic [1:0]             rsp_tuser
);

   localparam int CAP = (MAX_FRAMES > POOL_DEPTH) ? POOL_DEPTH : MAX_FRAMES;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type           state_ff, state_in;
   item_type            item_ff;
   logic [CNT_W-1:0]    pool_ff, pool_in;
   logic [CNT_W-1:0]    fresh_ff, fresh_in;
   logic [FRAME_W-1:0]  head_ff, head_in;
   logic [FRAME_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]    mcnt_ff, mcnt_in;
   logic [FRAME_W-1:0]  mem [POOL_DEPTH];
   logic [FRAME_W-1:0]  rd_data_ff;
   logic                push;

   // allocation map; only frames below the fresh counter have been written since restart
   logic                map_mem [POOL_DEPTH];
   logic                map_rd_ff;
   logic                map_we;
   logic [FRAME_W-1:0]  map_addr;
   logic                map_wdata;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          stat_ff, stat_in;
   logic [FRAME_W-1:0]  grant_ff, grant_in;
   logic [CNT_W-1:0]    acnt_ff, acnt_in;
   logic [CNT_W-1:0]    fcnt_ff, fcnt_in;
   logic [CNT_W-1:0]    psz_ff;

   logic                fire;
   logic [CNT_W:0]      dbl;
   logic [CNT_W-1:0]    free_tot;

   function automatic logic q_item_is_alloc(input item_type it);
      return it.op == OP_ALLOC;
   endfunction

   assign q_pop = (state_ff == ST_IDLE) && q_valid;
   assign fire  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = stat_ff;
   assign rsp_tdata  = {5'd0, psz_ff, fcnt_ff, acnt_ff, grant_ff};

   always_comb begin
      state_in     = state_ff;
      pool_in      = pool_ff;
      fresh_in     = fresh_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      mcnt_in      = mcnt_ff;
      push         = 1'b0;
      map_we       = 1'b0;
      map_addr     = item_ff.frame;
      map_wdata    = 1'b0;
      stat_in      = STAT_OK;
      grant_in     = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      dbl          = {pool_ff, 1'b0};

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (q_item_is_alloc(item_ff)) begin
                  if (fresh_ff < pool_ff) begin
                     grant_in = fresh_ff[FRAME_W-1:0];
                     fresh_in = fresh_ff + CNT_W'(1);
                  end else if (mcnt_ff != '0) begin
                     grant_in = rd_data_ff;
                     head_in  = head_ff + FRAME_W'(1);
                     mcnt_in  = mcnt_ff - CNT_W'(1);
                  end else if (pool_ff < CAP_CNT) begin
                     grant_in = pool_ff[FRAME_W-1:0];
                     fresh_in = pool_ff + CNT_W'(1);
                     pool_in  = (dbl > {1'b0, CAP_CNT}) ? CAP_CNT : dbl[CNT_W-1:0];
                  end else begin
                     stat_in = STAT_FULL;
                  end
                  if (stat_in == STAT_OK) begin
                     map_we    = 1'b1;
                     map_addr  = grant_in;
                     map_wdata = 1'b1;
                  end
               end else begin
                  if (({1'b0, item_ff.frame} < fresh_ff) && map_rd_ff) begin
                     map_we    = 1'b1;
                     map_addr  = item_ff.frame;
                     map_wdata = 1'b0;
                     push      = 1'b1;
                     tail_in   = tail_ff + FRAME_W'(1);
                     mcnt_in   = mcnt_ff + CNT_W'(1);
                  end else begin
                     stat_in = STAT_INVALID;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      free_tot = (pool_in - fresh_in) + mcnt_in;
      fcnt_in  = free_tot;
      acnt_in  = pool_in - free_tot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pool_ff      <= clamp_size(CNT_W'(RESET_POOL), CAP_CNT);
         fresh_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         mcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (restart.we) begin
         state_ff     <= ST_IDLE;
         pool_ff      <= clamp_size(restart.size, CAP_CNT);
         fresh_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         mcnt_ff      <= '0;
         rsp_valid_ff <= rsp_valid_ff && !rsp_tready;
      end else begin
         state_ff     <= state_in;
         pool_ff      <= pool_in;
         fresh_ff     <= fresh_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         mcnt_ff      <= mcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) item_ff <= q_item;
      if (fire) begin
         stat_ff  <= stat_in;
         grant_ff <= grant_in;
         acnt_ff  <= acnt_in;
         fcnt_ff  <= fcnt_in;
         psz_ff   <= pool_in;
      end
   end

   // free-frame FIFO memory
   always_ff @(posedge clock) begin
      if (push) mem[tail_ff] <= item_ff.frame;
      rd_data_ff <= mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_addr] <= map_wdata;
      if (q_pop) map_rd_ff <= map_mem[q_item.frame];
   end

endmodule

// ===== rtl/gfpa_checker.sv =====
// Port-level checker for the growable frame pool allocator, bound to the top level.
module gfpa_checker
   import gfpa_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF
)(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata,
   input logic [1:0]             rsp_tuser
);

   localparam int CAP = (MAX_FRAMES > POOL_DEPTH) ? POOL_DEPTH : MAX_FRAMES;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

   logic [CNT_W-1:0] acnt, fcnt, psz;
   assign acnt = rsp_tdata[16:8];
   assign fcnt = rsp_tdata[25:17];
   assign psz  = rsp_tdata[34:26];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   a_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CNT_W'(acnt + fcnt) == psz))
      else $error("allocated plus free differs from pool size");

   a_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (psz != '0) && (psz <= CAP_CNT))
      else $error("pool size out of range");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STAT_FULL) |->
         (fcnt == '0) && (psz == CAP_CNT) && (rsp_tdata[7:0] == '0))
      else $error("full reported with frames left");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STAT_OK) || (rsp_tuser == STAT_FULL) ||
                     (rsp_tuser == STAT_INVALID))
      else $error("undefined status code");

endmodule

bind growable_frame_pool_allocator gfpa_checker #(.MAX_FRAMES(MAX_FRAMES)) u_gfpa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== sim/growable_frame_pool_allocator_test.sv =====
// Self-checking testbench for the growable frame pool allocator: directed and random traffic.
module growable_frame_pool_allocator_test;
   import gfpa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP        = (MAX_FRAMES_DEF > POOL_DEPTH) ? POOL_DEPTH : MAX_FRAMES_DEF;
   localparam int LATENCY    = 4;
   localparam int LONG_HOLD  = 300;
   localparam int CYCLE_LIMIT = 800000;

   typedef struct {
      status_type        status;
      logic [FRAME_W-1:0] granted;
      logic [CNT_W-1:0]   alloc_cnt;
      logic [CNT_W-1:0]   free_cnt;
      logic [CNT_W-1:0]   pool_sz;
   } pool_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [FRAME_W-1:0]    req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CNT_W-1:0]      csr_data = '0;

   // predicted pool state
   logic [FRAME_W-1:0] pool_fifo [POOL_DEPTH];
   logic [FRAME_W-1:0] fifo_head;
   logic [FRAME_W-1:0] fifo_tail;
   logic [CNT_W-1:0]   fifo_count;
   bit                 frame_held [POOL_DEPTH];
   logic [CNT_W-1:0]   model_size;

   pool_result_type pending_results [$];
   int unsigned  mismatches = 0;
   int unsigned  cycles = 0;
   bit           req_nogap = 1'b0;
   int           req_burst_left = 0;
   bit           long_hold_req = 1'b0;

   growable_frame_pool_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic void fifo_push(input logic [FRAME_W-1:0] frame);
      pool_fifo[fifo_tail] = frame;
      fifo_tail++;
      fifo_count++;
   endfunction

   function automatic void restart_pool(input logic [CNT_W-1:0] size);
      int n;
      n = size;
      if (n == 0) n = 1;
      if (n > CAP) n = CAP;
      fifo_head = '0;
      fifo_tail = '0;
      fifo_count = '0;
      for (int i = 0; i < POOL_DEPTH; i++) frame_held[i] = 1'b0;
      for (int i = 0; i < n; i++) fifo_push(FRAME_W'(i));
      model_size = CNT_W'(n);
   endfunction

   function automatic pool_result_type predict_pool_step(input op_type op,
                                                          input logic [FRAME_W-1:0] frame);
      pool_result_type r;
      int           new_size;
      bit           ok;
      r.status = STAT_OK;
      r.granted = '0;
      if (op == OP_ALLOC) begin
         ok = 1'b1;
         if (fifo_count == 0) begin
            if (model_size < CAP) begin
               new_size = model_size * 2;
               if (new_size > CAP) new_size = CAP;
               for (int i = model_size; i < new_size; i++) fifo_push(FRAME_W'(i));
               model_size = CNT_W'(new_size);
            end else begin
               ok = 1'b0;
               r.status = STAT_FULL;
            end
         end
         if (ok) begin
            r.granted = pool_fifo[fifo_head];
            fifo_head++;
            fifo_count--;
            frame_held[r.granted] = 1'b1;
         end
      end else begin
         if (frame < model_size && frame_held[frame]) begin
            frame_held[frame] = 1'b0;
            fifo_push(frame);
         end else begin
            r.status = STAT_INVALID;
         end
      end
      r.alloc_cnt = model_size - fifo_count;
      r.free_cnt = fifo_count;
      r.pool_sz = model_size;
      return r;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int req_gap();
      if (req_nogap) return 0;
      if (req_burst_left > 0) begin
         req_burst_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) req_burst_left = $urandom_range(20, 80);
      return idle_len();
   endfunction

   function automatic bit pick_held_frame(output logic [FRAME_W-1:0] frame);
      int start;
      int idx;
      start = $urandom_range(0, POOL_DEPTH - 1);
      frame = '0;
      for (int k = 0; k < POOL_DEPTH; k++) begin
         idx = (start + k) % POOL_DEPTH;
         if (frame_held[idx]) begin
            frame = FRAME_W'(idx);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic send_request(input op_type op, input logic [FRAME_W-1:0] frame);
      int gap;
      req_tuser <= op;
      req_tdata <= frame;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(predict_pool_step(op, frame));
      gap = req_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random(input int alloc_pct);
      logic [FRAME_W-1:0] f;
      if ($urandom_range(0, 99) < alloc_pct) begin
         send_request(OP_ALLOC, FRAME_W'($urandom));
      end else if ($urandom_range(0, 9) < 8 && pick_held_frame(f)) begin
         send_request(OP_FREE, f);
      end else if ($urandom_range(0, 1) == 0) begin
         send_request(OP_FREE, FRAME_W'($urandom));
      end else begin
         send_request(OP_FREE, FRAME_W'($urandom_range(0, model_size - 1)));
      end
   endtask

   // stop offering items, then wait for every result plus the pipeline latency
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_start_size(input logic [CNT_W-1:0] size);
      drain();
      csr_data <= size;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      restart_pool(size);
   endtask

   task automatic report_mismatch(input string what, input int unsigned want_v,
                                  input int unsigned got_v);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %0d, got %0d", what, want_v, got_v);
   endtask

   always @(posedge clock) begin : result_check
      pool_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with none pending, status", 0, rsp_tuser);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser != want.status)
               report_mismatch("status", want.status, rsp_tuser);
            if (rsp_tdata[7:0] != want.granted)
               report_mismatch("granted_frame", want.granted, rsp_tdata[7:0]);
            if (rsp_tdata[16:8] != want.alloc_cnt)
               report_mismatch("allocated_count", want.alloc_cnt, rsp_tdata[16:8]);
            if (rsp_tdata[25:17] != want.free_cnt)
               report_mismatch("free_count", want.free_cnt, rsp_tdata[25:17]);
            if (rsp_tdata[34:26] != want.pool_sz)
               report_mismatch("current_pool_size", want.pool_sz, rsp_tdata[34:26]);
            if (rsp_tdata[39:35] != '0)
               report_mismatch("pad bits", 0, rsp_tdata[39:35]);
         end
      end
   end

   initial begin : rsp_ready_driver
      int  hold_left;
      int  run_left;
      bit  ready_next;
      hold_left = 0;
      run_left = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
            run_left = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            ready_next = 1'b1;
         end else begin
            hold_left = idle_len();
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 8);
            ready_next = (hold_left == 0);
            if (hold_left > 0) hold_left--;
         end
         rsp_tready <= ready_next;
      end
   end

   task automatic test_reset_pool();
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_ALLOC, 8'd255);
      send_request(OP_FREE, 8'd0);
      send_request(OP_FREE, 8'd0);
      send_request(OP_FREE, 8'd16);
      send_request(OP_FREE, 8'd255);
      send_request(OP_ALLOC, 8'd0);
      drain();
   endtask

   // size 0 is taken as 1; each empty-queue allocate doubles the pool
   task automatic test_pool_growth();
      write_start_size(9'd0);
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_FREE, 8'd3);
      send_request(OP_FREE, 8'd1);
      send_request(OP_FREE, 8'd1);
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_ALLOC, 8'd0);
      drain();
   endtask

   task automatic test_size_extremes();
      write_start_size(9'd511);
      send_request(OP_ALLOC, 8'd255);
      send_request(OP_FREE, 8'd255);
      send_request(OP_FREE, 8'd0);
      write_start_size(9'd256);
      send_request(OP_ALLOC, 8'd0);
      write_start_size(9'd1);
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_FREE, 8'd0);
      send_request(OP_FREE, 8'd0);
      drain();
   endtask

   task automatic test_random_mix();
      logic [CNT_W-1:0] size;
      int               pct;
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin size = 9'd16; pct = 60; end
            1: begin size = 9'd1; pct = 55; end
            2: begin size = 9'd256; pct = 50; end
            3: begin size = CNT_W'($urandom_range(2, 255)); pct = 65; end
            default: begin size = CNT_W'($urandom_range(0, 511)); pct = 55; end
         endcase
         write_start_size(size);
         repeat (90) send_random(pct);
      end
      drain();
   endtask

   task automatic test_pool_exhaustion();
      write_start_size(9'd300);
      repeat (340) send_random(92);
      write_start_size(9'd1);
      repeat (340) send_random(90);
      drain();
   endtask

   task automatic test_output_backpressure();
      req_nogap = 1'b1;
      long_hold_req = 1'b1;
      repeat (60) send_random(50);
      req_nogap = 1'b0;
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      restart_pool(CNT_W'(RESET_POOL));
      test_reset_pool();
      test_pool_growth();
      test_size_extremes();
      test_random_mix();
      test_pool_exhaustion();
      test_output_backpressure();
      drain();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
